/* sv/etf_pkg.sv */
// Shared types, constants and helper functions for the escape-time iterator.
// Used by etf_ctrl, etf_datapath and escape_time_fractal_iterator; no dependencies.
`timescale 1ns / 1ps

package etf_pkg;

    // Iteration limit and the widths that follow from it.
    localparam int MAX_ITER   = 256;
    localparam int CNT_W      = $clog2(MAX_ITER + 1);
    localparam int ITER_OUT_W = 9;

    // Q3.28 operands and exact Q7.56 products.
    localparam int DATA_W = 32;
    localparam int FRAC_W = 28;
    localparam int PROD_W = 2 * DATA_W;
    localparam int RE_W   = PROD_W + 2;
    localparam int IM_W   = PROD_W + 1;
    localparam int SH_W   = RE_W - FRAC_W;

    localparam logic [DATA_W-1:0] RADIUS_RESET = 32'h4000_0000;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RR   = 5'b00010,
        ST_II   = 5'b00100,
        ST_RI   = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic mul_rr;
        logic mul_ii;
        logic mul_ri;
        logic update;
    } ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic escape;
    } stat_t;

    // Clamp a shifted sum to the Q3.28 range.
    function automatic logic signed [DATA_W-1:0] sat_q328(input logic signed [SH_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[SH_W-1:DATA_W-1] != {(SH_W-DATA_W+1){v[DATA_W-1]}}) begin
            r = v[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/escape_time_fractal_iterator.sv */
// Top level of the escape-time iterator: configuration register, output register,
// sequencer and datapath. Depends on etf_pkg, etf_ctrl and etf_datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   s_start_re, s_start_im, s_const_re, s_const_im
//  m_       out        m_valid / m_ready   m_iterations
//  cfg_     in         cfg_wr_en           cfg_wr_data (escape_radius_sq)
//
//  For every iteration of z = z*z + c one 32x32 multiplier forms re*re, im*im and
//  re*im in turn, and a further step adds c, shifts and clamps. An item finishes at
//  the iteration at which it escapes, or after MAX_ITER iterations if it never does;
//  the sequencer then returns to idle, so items are taken one at a time.
//  Reset (synchronous, active low) returns the sequencer to idle, empties the output
//  register and restores the squared escape radius to 4.0.
//  The next item is taken as soon as the sequencer is idle, even while a result still
//  waits in the output register; a stalled output holds a finished item in the sequencer.

module escape_time_fractal_iterator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [etf_pkg::DATA_W-1:0]     s_start_re,
    input  logic signed [etf_pkg::DATA_W-1:0]     s_start_im,
    input  logic signed [etf_pkg::DATA_W-1:0]     s_const_re,
    input  logic signed [etf_pkg::DATA_W-1:0]     s_const_im,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [etf_pkg::ITER_OUT_W-1:0] m_iterations,
    input  logic                                  cfg_wr_en,
    input  logic        [etf_pkg::DATA_W-1:0]     cfg_wr_data
);
    import etf_pkg::*;

    logic [DATA_W-1:0]     radius_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [ITER_OUT_W-1:0] m_iter_reg, m_iter_next;
    logic                  out_free;
    logic                  done;
    logic [CNT_W-1:0]      result;
    ctl_t                  ctl;
    stat_t                 stat;

    // The output register can take a new result when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;

    etf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .stat     (stat),
        .ctl      (ctl),
        .done     (done),
        .result   (result)
    );

    etf_datapath u_datapath (
        .aclk             (aclk),
        .ctl              (ctl),
        .start_re         (s_start_re),
        .start_im         (s_start_im),
        .const_re         (s_const_re),
        .const_im         (s_const_im),
        .escape_radius_sq (radius_reg),
        .stat             (stat)
    );

    // The count is masked to the width of the result field.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_iter_next  = m_iter_reg;
        if (done) begin
            m_valid_next = 1'b1;
            m_iter_next  = ITER_OUT_W'(result);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
        m_iter_reg <= m_iter_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_iterations = m_iter_reg;

`ifndef SYNTHESIS
    // A result is only finished into a free output register.
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free)
        else $error("result finished while output register full");

    // Once an item is taken the block is busy until its result is done.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    // After finishing the block is idle again.
    a_idle_after: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> s_ready)
        else $error("block not idle after finishing an item");

    // A finished item can never report more than the iteration limit.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (result <= CNT_W'(MAX_ITER)))
        else $error("iteration count out of range");
`endif

endmodule

/* sv/etf_datapath.sv */
// Datapath of the escape-time iterator: z and c registers, the shared multiplier,
// the update with saturation and the escape compare. Depends on etf_pkg.
`timescale 1ns / 1ps

module etf_datapath (
    input  logic                                 aclk,
    input  etf_pkg::ctl_t                        ctl,
    input  logic signed [etf_pkg::DATA_W-1:0]    start_re,
    input  logic signed [etf_pkg::DATA_W-1:0]    start_im,
    input  logic signed [etf_pkg::DATA_W-1:0]    const_re,
    input  logic signed [etf_pkg::DATA_W-1:0]    const_im,
    input  logic        [etf_pkg::DATA_W-1:0]    escape_radius_sq,
    output etf_pkg::stat_t                       stat
);
    import etf_pkg::*;

    logic signed [DATA_W-1:0] re_reg, im_reg, cre_reg, cim_reg;
    logic signed [DATA_W-1:0] re_next, im_next;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg, diff_reg;
    logic signed [DATA_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [RE_W-1:0]   sum_re;
    logic signed [IM_W-1:0]   sum_im;
    logic signed [SH_W-1:0]   sh_re, sh_im;
    logic        [PROD_W:0]   norm;
    logic        [PROD_W:0]   limit;

    // The one multiplier; its operands follow the current step.
    always_comb begin
        op_a = re_reg;
        op_b = ctl.mul_ii ? im_reg : re_reg;
        if (ctl.mul_ii) begin
            op_a = im_reg;
        end
        if (ctl.mul_ri) begin
            op_b = im_reg;
        end
        prod = op_a * op_b;
    end

    // Squares are never negative, so the norm is an unsigned add.
    assign norm  = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign limit = (PROD_W + 1)'({escape_radius_sq, {FRAC_W{1'b0}}});
    assign stat.escape = (norm >= limit);

    // New z: exact sums, floor shift, then clamp to Q3.28.
    always_comb begin
        sum_re  = RE_W'(diff_reg) + (RE_W'(cre_reg) <<< FRAC_W);
        sum_im  = IM_W'(ri_reg) + (IM_W'(cim_reg) <<< (FRAC_W - 1));
        sh_re   = SH_W'(sum_re >>> FRAC_W);
        sh_im   = SH_W'(sum_im >>> (FRAC_W - 1));
        re_next = sat_q328(sh_re);
        im_next = sat_q328(sh_im);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            re_reg  <= start_re;
            im_reg  <= start_im;
            cre_reg <= const_re;
            cim_reg <= const_im;
        end else if (ctl.update) begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
        if (ctl.mul_rr) begin
            rr_reg <= prod;
        end
        if (ctl.mul_ii) begin
            ii_reg <= prod;
        end
        if (ctl.mul_ri) begin
            ri_reg   <= prod;
            diff_reg <= rr_reg - ii_reg;
        end
    end

endmodule

/* sv/etf_ctrl.sv */
// Sequencer of the escape-time iterator: steps the shared multiplier, counts
// iterations and decides when an item is finished. Depends on etf_pkg.
`timescale 1ns / 1ps

module etf_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         out_free,
    input  etf_pkg::stat_t               stat,
    output etf_pkg::ctl_t                ctl,
    output logic                         done,
    output logic [etf_pkg::CNT_W-1:0]    result
);
    import etf_pkg::*;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic   finish;

    // The start point is never tested: the first test follows the first update.
    assign finish = !first_reg && (stat.escape || iter_reg == CNT_W'(MAX_ITER - 1));
    assign result = stat.escape ? iter_reg : CNT_W'(MAX_ITER);

    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.load   = 1'b1;
                    first_next = 1'b1;
                    iter_next  = '0;
                    state_next = ST_RR;
                end
            end
            ST_RR: begin
                ctl.mul_rr = 1'b1;
                state_next = ST_II;
            end
            ST_II: begin
                ctl.mul_ii = 1'b1;
                state_next = ST_RI;
            end
            ST_RI: begin
                ctl.mul_ri = 1'b1;
                if (finish) begin
                    if (out_free) begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                ctl.update = 1'b1;
                if (first_reg) begin
                    first_next = 1'b0;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
                state_next = ST_RR;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

/* bench/tb.sv */
// Self-checking testbench for escape_time_fractal_iterator: Julia and Mandelbrot items,
// several squared escape radii, random idling on both channels and a long output stall.
// Depends on etf_pkg and the escape_time_fractal_iterator RTL; nothing else.
`timescale 1ns / 1ps

module tb;

    localparam int           DW       = etf_pkg::DATA_W;
    localparam int           IW       = etf_pkg::ITER_OUT_W;
    localparam longint       Q328_MAX = 64'sd2147483647;
    localparam longint       Q328_MIN = -64'sd2147483648;
    localparam logic [DW-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] NEG_MIN = 32'h8000_0000;
    // Cycles allowed after the last result before the sequencer is taken to be idle.
    localparam int           SETTLE   = 8;

    // Clock, reset and every block input start at a known value.
    logic          aclk        = 1'b0;
    logic          aresetn     = 1'b0;
    logic          s_valid     = 1'b0;
    logic          s_ready;
    logic [DW-1:0] s_start_re  = '0;
    logic [DW-1:0] s_start_im  = '0;
    logic [DW-1:0] s_const_re  = '0;
    logic [DW-1:0] s_const_im  = '0;
    logic          m_valid;
    logic          m_ready     = 1'b0;
    logic [IW-1:0] m_iterations;
    logic          cfg_wr_en   = 1'b0;
    logic [DW-1:0] cfg_wr_data = '0;

    // One outstanding item: what was sent, under which radius, and the iteration
    // index that the block must return for it.
    typedef struct packed {
        logic [DW-1:0] zr;
        logic [DW-1:0] zi;
        logic [DW-1:0] cr;
        logic [DW-1:0] ci;
        logic [DW-1:0] radius;
        logic [IW-1:0] iters;
    } escape_rec_t;

    escape_rec_t   pending_escapes[$];
    logic [DW-1:0] radius_sq    = etf_pkg::RADIUS_RESET;
    int unsigned   mismatches   = 0;
    bit            src_gaps     = 1'b1;
    bit            sink_gaps    = 1'b1;
    int unsigned   hold_request = 0;
    logic [DW-1:0] julia_cr     = '0;
    logic [DW-1:0] julia_ci     = '0;

    always #1 aclk = ~aclk;

    escape_time_fractal_iterator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_re   (s_start_re),
        .s_start_im   (s_start_im),
        .s_const_re   (s_const_re),
        .s_const_im   (s_const_im),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iterations (m_iterations),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Clamp a shifted sum back into the signed Q3.28 range.
    function automatic longint clamp_q328(input longint v);
        if (v > Q328_MAX) begin
            return Q328_MAX;
        end
        if (v < Q328_MIN) begin
            return Q328_MIN;
        end
        return v;
    endfunction

    // Iterate z = z*z + c from the given start and return the index of the first
    // iteration whose squared modulus reaches the radius, or MAX_ITER if none does.
    // Products are exact in 64 bits; the arithmetic right shifts round towards minus
    // infinity, and the imaginary part carries the factor of two in its shift.
    function automatic logic [IW-1:0] escape_index(input logic signed [DW-1:0] zr0,
                                                   input logic signed [DW-1:0] zi0,
                                                   input logic signed [DW-1:0] cr,
                                                   input logic signed [DW-1:0] ci,
                                                   input logic [DW-1:0] radius);
        longint          zr;
        longint          zi;
        longint          nre;
        longint          nim;
        longint unsigned norm;
        longint unsigned bound;
        int              n;
        zr    = zr0;
        zi    = zi0;
        bound = {radius, 28'd0};
        for (n = 0; n < etf_pkg::MAX_ITER; n++) begin
            nre  = zr * zr - zi * zi + (longint'(cr) <<< 28);
            nim  = zr * zi + (longint'(ci) <<< 27);
            zr   = clamp_q328(nre >>> 28);
            zi   = clamp_q328(nim >>> 27);
            norm = $unsigned(zr * zr) + $unsigned(zi * zi);
            if (norm >= bound) begin
                break;
            end
        end
        return IW'(n);
    endfunction

    // Offer one item after a random idle spell and wait until it is taken. Valid is
    // left high on return, so a following item goes out back to back unless the
    // next draw asks for a gap.
    task automatic send_point(input logic [DW-1:0] zr, input logic [DW-1:0] zi,
                              input logic [DW-1:0] cr, input logic [DW-1:0] ci);
        int unsigned pause;
        escape_rec_t rec;
        pause = src_gaps ? $urandom_range(0, 14) : 0;
        if (pause != 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_start_re <= zr;
        s_start_im <= zi;
        s_const_re <= cr;
        s_const_im <= ci;
        do @(posedge aclk); while (s_ready !== 1'b1);
        rec.zr     = zr;
        rec.zi     = zi;
        rec.cr     = cr;
        rec.ci     = ci;
        rec.radius = radius_sq;
        rec.iters  = escape_index(zr, zi, cr, ci, radius_sq);
        pending_escapes.push_back(rec);
    endtask

    // Mostly well-formed points: Mandelbrot pixels in the region of interest, Julia
    // pixels around the origin against a constant that changes now and then, and a
    // fifth of the time raw 32-bit noise that reaches every bit and the saturation.
    task automatic send_random_point();
        int unsigned   pick;
        logic [DW-1:0] zr;
        logic [DW-1:0] zi;
        logic [DW-1:0] cr;
        logic [DW-1:0] ci;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            zr = '0;
            zi = '0;
            cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
            ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
        end else if (pick < 8) begin
            zr = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            zi = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            cr = julia_cr;
            ci = julia_ci;
        end else begin
            zr = $urandom;
            zi = $urandom;
            cr = $urandom;
            ci = $urandom;
        end
        send_point(zr, zi, cr, ci);
    endtask

    task automatic new_julia_constant();
        julia_cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
        julia_ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
    endtask

    // Drop valid and wait until every outstanding item has produced its result, then
    // let the sequencer fall back to idle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // The radius register is only ever written with the block idle.
    task automatic set_radius(input logic [DW-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        radius_sq    = value;
    endtask

    // Points with known behaviour under the squared radius left by reset (4.0).
    task automatic test_directed_default();
        send_point('0, '0, '0, '0);                              // origin never moves
        send_point('0, '0, 32'h2000_0000, '0);                   // lands exactly on radius 2
        send_point('0, '0, 32'h1FFF_FFFF, '0);                   // one lsb short of it
        send_point('0, '0, '0, 32'h2000_0000);                   // exactly 2i
        send_point('0, '0, -32'sh2000_0000, '0);                 // tip of the set at -2
        send_point('0, '0, -32'sh1000_0000, '0);                 // orbit alternates between -1 and 0
        send_point('0, '0, 32'h0400_0000, '0);                   // cusp at 0.25
        send_point('0, '0, 32'h0428_F5C3, '0);                   // just past the cusp
        send_point('0, '0, -32'sh1C00_0000, '0);                 // period-three window
        send_point('0, '0, '0, 32'h1000_0000);                   // c = i stays bounded
        send_point('0, '0, -32'sh0C00_0000, 32'h0199_999A);      // near the neck
        send_point('0, '0, -32'sh0199_999A, 32'h0A6A_7EFA);      // near the boundary
        send_point(32'h0199_999A, 32'h0199_999A, -32'sh0CCC_CCCD, 32'h027E_F9DB);
        // A start outside the radius is not tested; here it falls back to zero first.
        send_point(32'h2800_0000, '0, -32'sh6400_0000, '0);
        send_point(32'h3000_0000, 32'h3000_0000, '0, '0);        // imaginary part saturates
        send_point(POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        send_point(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
        send_point(NEG_MIN, '0, POS_MAX, '0);
        send_point(POS_MAX, NEG_MIN, NEG_MIN, POS_MAX);
        send_point('1, '1, '0, '0);                              // tiny negatives round down
        send_point('0, '0, '1, '1);
    endtask

    // The receiver stops for a long spell after the next result, so the output
    // register and the sequencer both fill and the input has to stall.
    task automatic test_output_backpressure();
        wait_idle();
        src_gaps     = 1'b0;
        hold_request = 400;
        repeat (10) send_point('0, '0, 32'h3000_0000, '0);
        src_gaps     = 1'b1;
    endtask

    // With a zero radius every item escapes at its first iteration.
    task automatic test_zero_radius();
        set_radius('0);
        repeat (30) send_random_point();
    endtask

    // The largest squared radius (just under 16): points that settle inside it never escape,
    // while saturated ones still do.
    task automatic test_full_scale_radius();
        set_radius('1);
        send_point('0, '0, '0, '0);
        send_point('0, '0, -32'sh2000_0000, '0);
        send_point('0, '0, POS_MAX, POS_MAX);
        send_point(NEG_MIN, '0, '0, '0);
        send_point(POS_MAX, POS_MAX, NEG_MIN, NEG_MIN);
        repeat (20) send_random_point();
    endtask

    // The smallest non-zero squared radius: only points whose squared modulus stays under one Q3.28 lsb survive.
    task automatic test_minimum_radius();
        set_radius(32'h0000_0001);
        send_point('0, '0, '0, '0);
        send_point('1, '0, '0, '0);
        repeat (28) send_random_point();
    endtask

    task automatic test_random_radius();
        int k;
        for (k = 0; k < 4; k++) begin
            set_radius(k == 0 ? 32'h9000_0000 : $urandom);
            new_julia_constant();
            repeat (40) send_random_point();
        end
    endtask

    // The bulk of the run at the usual radius of 2, with idling switched on and off
    // in stretches on both sides.
    task automatic test_random_points();
        int k;
        set_radius(etf_pkg::RADIUS_RESET);
        for (k = 0; k < 480; k++) begin
            if (k % 16 == 0) begin
                new_julia_constant();
            end
            if (k % 60 == 0) begin
                src_gaps  = ($urandom_range(0, 2) != 0);
                sink_gaps = ($urandom_range(0, 2) != 0);
            end
            send_random_point();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Result receiver: ready is lowered for a random number of cycles before each
    // item, or for the long hold when one has been asked for.
    initial begin : result_sink
        int unsigned pause;
        wait (aresetn === 1'b1);
        forever begin
            pause = sink_gaps ? $urandom_range(0, 14) : 0;
            if (hold_request != 0) begin
                pause        = hold_request;
                hold_request = 0;
            end
            if (pause != 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Every accepted result is matched against the oldest outstanding item.
    always @(posedge aclk) begin : result_check
        escape_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_escapes.size() == 0) begin
                mismatches++;
                $display("%0t: result with no item outstanding: expected none, got %0d",
                         $time, m_iterations);
            end else begin
                want = pending_escapes.pop_front();
                if (m_iterations !== want.iters) begin
                    mismatches++;
                    $display("%0t: iterations expected %0d, got %0d (z0 %h %h c %h %h r2 %h)",
                             $time, want.iters, m_iterations, want.zr, want.zi,
                             want.cr, want.ci, want.radius);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_default();
        test_output_backpressure();
        test_zero_radius();
        test_full_scale_radius();
        test_minimum_radius();
        test_random_radius();
        test_random_points();
        wait_idle();
        // Leave room for any stray result to show up before the verdict.
        repeat (64) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Several times the slowest correct run: every item running all iterations
    // with both sides idling for as long as they ever do.
    initial begin
        #16_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/etf_pkg.sv
sv/etf_datapath.sv
sv/etf_ctrl.sv
sv/escape_time_fractal_iterator.sv
bench/tb.sv
